// ===== hw/rtl/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants for the pedal cadence meter
// field widths, register reset value and rate saturation code
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

  localparam int TIME_W = 32;
  localparam int TPM_W  = 27;
  localparam int RATE_W = 32;
  localparam int NUM_W  = TPM_W + 4;

  localparam logic [TPM_W-1:0]  TPM_RESET = TPM_W'(60000000);
  localparam logic [RATE_W-1:0] RATE_SAT  = {RATE_W{1'b1}};

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [RATE_W-1:0] rate_t;

  typedef struct packed {
    logic start;
    num_t num;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcm_ram.sv =====
// ----------------------------------------------------------------------------
// pcm_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire  [WIDTH-1:0]          wr_data,
  input  wire                       rd_en,
  input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcm_divider.sv =====
// ----------------------------------------------------------------------------
// pcm_divider: bit-serial restoring divider
// one quotient bit per cycle, done pulses at end
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_divider #(
  parameter int DEN_W = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  pcm_pkg::div_req_t         req,
  input  wire  [DEN_W-1:0]          den,
  output logic                      done,
  output pcm_pkg::num_t             quot
);

  import pcm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  num_t             num_sr;

  logic [DEN_W:0]   rem2;
  logic             ge;
  logic [DEN_W:0]   diff;

  always_comb begin
    rem2 = {rem, num_sr[NUM_W-1]};
    ge   = rem2 >= {1'b0, den_r};
    diff = rem2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem    <= '0;
      den_r  <= den;
      num_sr <= req.num;
    end else if (busy) begin
      rem    <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      num_sr <= {num_sr[NUM_W-2:0], ge};
    end
  end

  assign quot = num_sr;

endmodule

`default_nettype wire

// ===== hw/rtl/pedal_cadence_meter_top.sv =====
// ----------------------------------------------------------------------------
// pedal_cadence_meter_top: crank cadence from magnet pulse timestamps
// one pulse in work at a time, paced by the two bit-serial dividers
// (31 quotient bits each, run side by side) plus ring read and setup
// input is taken again while a result waits in the output register
// rst is synchronous; no ring clearing, counters and handshake reset at once
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_cadence_meter_top #(
  parameter int MAGNETS = 12
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_wr_en,
  input  wire  [pcm_pkg::TPM_W-1:0] cfg_wr_data,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  input  wire  [31:0]               s_tdata,   // pulse_time
  output logic                      m_tvalid,
  input  wire                       m_tready,
  output logic [63:0]               m_tdata,   // instant_rate, average_rate
  output logic [7:0]                m_tuser    // instant_valid, average_valid,
                                               // zero_interval, zero fill
);

  import pcm_pkg::*;

  localparam int SLOT_W = $clog2(MAGNETS);
  localparam int CNT_W  = $clog2(MAGNETS + 2);
  localparam int DEN_W  = TIME_W + $clog2(MAGNETS + 1);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAGNETS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAGNETS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic [TPM_W-1:0]  tpm;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  pulse_cnt;
  logic [CNT_W-1:0]  cnt_next;

  time_t             cur_time;
  time_t             last_time;
  time_t             old_time;
  time_t             d_inst;
  time_t             d_avg;
  logic              inst_ok;
  logic              avg_ok;
  logic              inst_zero;
  logic              avg_zero;

  div_req_t          req;
  logic [DEN_W-1:0]  den_inst;
  time_t             den_avg;
  logic              inst_done;
  logic              avg_done;
  num_t              q_inst;
  num_t              q_avg;

  rate_t             inst_rate;
  rate_t             avg_rate;

  logic              in_fire;
  logic              out_free;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  assign cnt_next = (pulse_cnt == CNT_FULL) ? pulse_cnt : pulse_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm <= TPM_RESET;
    end else if (cfg_wr_en) begin
      tpm <= cfg_wr_data;
    end
  end

  pcm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAGNETS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == ST_READ),
    .wr_addr (slot),
    .wr_data (cur_time),
    .rd_en   (in_fire),
    .rd_addr (slot),
    .rd_data (old_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= '0;
      pulse_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          slot      <= (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
          pulse_cnt <= cnt_next;
          state     <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (inst_done && avg_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_time <= s_tdata;
    end
    if (state == ST_READ) begin
      d_inst    <= cur_time - last_time;
      d_avg     <= cur_time - old_time;
      last_time <= cur_time;
      inst_ok   <= cnt_next >= CNT_W'(2);
      avg_ok    <= cnt_next == CNT_FULL;
    end
    if (state == ST_MUL) begin
      inst_zero <= d_inst == '0;
      avg_zero  <= d_avg == '0;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= {avg_rate, inst_rate};
      m_tuser <= {5'b00000, (inst_ok && inst_zero) || (avg_ok && avg_zero), avg_ok, inst_ok};
    end
  end

  always_comb begin
    req.start = (state == ST_MUL);
    req.num   = {tpm, 4'b0000};
    den_inst  = DEN_W'(d_inst) * DEN_W'(MAGNETS);
    den_avg   = d_avg;
  end

  pcm_divider #(
    .DEN_W (DEN_W)
  ) u_div_inst (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .den  (den_inst),
    .done (inst_done),
    .quot (q_inst)
  );

  pcm_divider #(
    .DEN_W (TIME_W)
  ) u_div_avg (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .den  (den_avg),
    .done (avg_done),
    .quot (q_avg)
  );

  always_comb begin
    if (!inst_ok) begin
      inst_rate = '0;
    end else if (inst_zero) begin
      inst_rate = RATE_SAT;
    end else begin
      inst_rate = RATE_W'(q_inst);
    end
    if (!avg_ok) begin
      avg_rate = '0;
    end else if (avg_zero) begin
      avg_rate = RATE_SAT;
    end else begin
      avg_rate = RATE_W'(q_avg);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcm_checker.sv =====
// ----------------------------------------------------------------------------
// pcm_checker: port-level checks for the pedal cadence meter
// watches handshake and output flag consistency, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tvalid,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [63:0]                m_tdata,
  input wire [7:0]                 m_tuser
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // one pulse in work at a time
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // invalid rates read as zero
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tdata[31:0] == 32'd0) &&
                 (m_tuser[1] || m_tdata[63:32] == 32'd0))
    else $error("invalid rate not zero");

  // full ring implies an instant rate
  a_avg_inst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("average valid without instant valid");

  // zero interval comes with a saturated rate
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |->
      (m_tdata[31:0] == 32'hFFFFFFFF || m_tdata[63:32] == 32'hFFFFFFFF))
    else $error("zero interval without saturation");

endmodule

bind pedal_cadence_meter_top pcm_checker u_pcm_checker (.*);

`default_nettype wire

// ===== tb/pedal_cadence_meter_top_test.sv =====
// ----------------------------------------------------------------------------
// pedal_cadence_meter_top_test: self-checking bench for the cadence meter
// streams magnet pulse stamps through the block under several ticks-per-minute
// settings and random idling on both sides, predicts each instantaneous and
// average rate in the bench, and compares every output transaction
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_cadence_meter_top_test;
  import pcm_pkg::*;

  localparam int MAGNETS    = 12;
  localparam int RING_DEPTH = MAGNETS + 1;
  localparam int LIMIT      = 500000;
  localparam int PHASE_PULSES = 140;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    rate_t instant;
    logic  instant_ok;
    rate_t average;
    logic  average_ok;
    logic  zero_seen;
  } cadence_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [TPM_W-1:0]  cfg_wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;
  logic [7:0]        m_tuser;

  pedal_cadence_meter_top #(.MAGNETS(MAGNETS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // predictor state
  time_t            stamp_ring [RING_DEPTH];
  int unsigned      newest_slot;
  bit               ring_full;
  logic [TPM_W-1:0] tpm_now;

  time_t       pulse_q [$];
  cadence_t    cadence_q [$];
  cadence_t    want;
  bit          offering;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cnt = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned pulses_taken = 0;
  int unsigned results_seen = 0;
  int unsigned zero_results = 0;
  int unsigned tpm_writes = 0;
  time_t       last_stamp;

  function automatic rate_t crank_rate(time_t interval, int unsigned scale, inout bit zero);
    logic [63:0] num;
    logic [63:0] den;
    num = 64'(tpm_now) << 4;
    den = 64'(interval) * 64'(scale);
    if (den == 0) begin
      zero = 1'b1;
      return RATE_SAT;
    end
    return rate_t'(num / den);
  endfunction

  function automatic cadence_t predict_cadence(time_t stamp);
    cadence_t    r;
    bit          zero;
    int unsigned prev;
    int unsigned oldest;
    r = '0;
    zero = 1'b0;
    newest_slot = (newest_slot >= MAGNETS) ? 0 : newest_slot + 1;
    stamp_ring[newest_slot] = stamp;
    if (newest_slot == MAGNETS) ring_full = 1'b1;
    r.instant_ok = ring_full || (newest_slot >= 1 && newest_slot != MAGNETS);
    r.average_ok = ring_full;
    if (r.instant_ok) begin
      prev = (newest_slot == 0) ? MAGNETS : newest_slot - 1;
      r.instant = crank_rate(stamp - stamp_ring[prev], MAGNETS, zero);
    end
    if (r.average_ok) begin
      oldest = (newest_slot >= MAGNETS) ? 0 : newest_slot + 1;
      r.average = crank_rate(stamp - stamp_ring[oldest], 1, zero);
    end
    r.zero_seen = zero;
    return r;
  endfunction

  function automatic time_t next_interval();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return time_t'($urandom_range(1, 15));
      3, 4, 5,
      6:       return time_t'($urandom_range(16, 100000));
      7, 8:    return time_t'($urandom_range(100000, 20000000));
      default: return time_t'($urandom);
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        cadence_q.push_back(predict_cadence(s_tdata));
        pulses_taken++;
        offering = 1'b0;
      end
      if (!offering && pulse_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= pulse_q.pop_front();
        offering = 1'b1;
      end
      s_tvalid <= offering;
    end
  end

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, expected, actual);
      errors++;
    end
  endtask

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (cadence_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %h %h",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = cadence_q.pop_front();
          if (want.zero_seen) zero_results++;
          check_field("instant_rate", want.instant, m_tdata[31:0]);
          check_field("average_rate", want.average, m_tdata[63:32]);
          check_field("instant_valid", 32'(want.instant_ok), 32'(m_tuser[0]));
          check_field("average_valid", 32'(want.average_ok), 32'(m_tuser[1]));
          check_field("zero_interval", 32'(want.zero_seen), 32'(m_tuser[2]));
        end
      end
      m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_cnt <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pulse_q.size() != 0 || s_tvalid || cadence_q.size() != 0);
  endtask

  task automatic write_tpm(input logic [TPM_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tpm_now = value;
    tpm_writes++;
    @(negedge clk);
  endtask

  initial begin
    logic [TPM_W-1:0] tpm_plan [6];
    time_t            stamp;
    newest_slot = MAGNETS;
    ring_full   = 1'b0;
    tpm_now     = TPM_RESET;
    tpm_plan[0] = TPM_W'(1);
    tpm_plan[1] = TPM_W'(100000000);
    tpm_plan[2] = '0;
    tpm_plan[3] = '1;
    tpm_plan[4] = TPM_W'($urandom_range(1, 100000000));
    tpm_plan[5] = TPM_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first pulse, second pulse, zero interval, wrap of the timer, unit interval
    send_idle_pct = 28;
    recv_idle_pct = 61;
    pulse_q.push_back(32'h0);
    pulse_q.push_back(32'd1000);
    pulse_q.push_back(32'd1000);
    pulse_q.push_back(32'hFFFF_FFF0);
    pulse_q.push_back(32'h0000_0010);
    pulse_q.push_back(32'h0000_0011);
    stamp = 32'h0000_0011;
    for (int k = 0; k < 7; k++) begin
      stamp = stamp + 40000 * (k + 1);
      pulse_q.push_back(stamp);
    end
    // a full rotation of equal stamps gives a zero span for the average
    for (int k = 0; k < RING_DEPTH; k++) pulse_q.push_back(32'hFFFF_FFFF);
    last_stamp = 32'hFFFF_FFFF;
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 28 : (phase < 4) ? 61 : 0;
      recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 28 : 0;
      write_tpm(tpm_plan[phase]);
      for (int n = 0; n < PHASE_PULSES; n++) begin
        last_stamp = last_stamp + next_interval();
        pulse_q.push_back(last_stamp);
      end
      if (phase == 4) begin
        hold_req = 1'b1;
        do @(negedge clk); while (hold_cnt == 0);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    $display("checked %0d results from %0d pulses, %0d with a zero interval",
             results_seen, pulses_taken, zero_results);
    $display("covered %0d ticks-per-minute writes plus the reset value, idling on both sides",
             tpm_writes);
    if (errors == 0 && cadence_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
